/* sv/ttoi_pkg.sv */
package ttoi_pkg;

  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_t;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_MINUS  = 4'b0010,
    PH_ZERO   = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef enum logic {
    REG_BASE_MODE   = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_index_t;

  localparam int unsigned CharWidth  = 16;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CfgWidth   = 2;

  localparam logic [CharWidth-1:0] CH_NUL   = 16'h0000;
  localparam logic [CharWidth-1:0] CH_MINUS = 16'h002d;
  localparam logic [CharWidth-1:0] CH_0     = 16'h0030;
  localparam logic [CharWidth-1:0] CH_7     = 16'h0037;
  localparam logic [CharWidth-1:0] CH_9     = 16'h0039;
  localparam logic [CharWidth-1:0] CH_UA    = 16'h0041;
  localparam logic [CharWidth-1:0] CH_UF    = 16'h0046;
  localparam logic [CharWidth-1:0] CH_UX    = 16'h0058;
  localparam logic [CharWidth-1:0] CH_LA    = 16'h0061;
  localparam logic [CharWidth-1:0] CH_LF    = 16'h0066;
  localparam logic [CharWidth-1:0] CH_LX    = 16'h0078;

  localparam logic [ValueWidth-1:0] HEX_LIMIT = 64'h0fff_ffff_ffff_ffff;
  localparam logic [ValueWidth-1:0] OCT_LIMIT = 64'h1fff_ffff_ffff_ffff;
  localparam logic [ValueWidth-1:0] DEC_LIMIT = 64'h1999_9999_9999_9999;
  localparam logic [ValueWidth-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
  localparam logic [ValueWidth-1:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic                  good;
    logic [ValueWidth-1:0] acc;
  } digit_res_t;

  // Appends one character as a digit of the given base. On a bad digit or an
  // overflow the accumulator is returned unchanged with good low.
  function automatic digit_res_t add_digit(base_t b, logic [ValueWidth-1:0] acc,
                                           logic [CharWidth-1:0] c);
    digit_res_t r;
    logic [3:0] d;
    r.good = 1'b0;
    r.acc  = acc;
    d      = c[3:0];
    case (b)
      BASE_HEX: begin
        if (c inside {[CH_0:CH_9]}) begin
          r.good = 1'b1;
        end else if (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]}) begin
          r.good = 1'b1;
          d      = c[3:0] + 4'd9;
        end
        if (acc > HEX_LIMIT) r.good = 1'b0;
        if (r.good) r.acc = {acc[ValueWidth-5:0], d};
      end
      BASE_OCT: begin
        r.good = (c inside {[CH_0:CH_7]}) && (acc <= OCT_LIMIT);
        if (r.good) r.acc = {acc[ValueWidth-4:0], c[2:0]};
      end
      default: begin
        r.good = (c inside {[CH_0:CH_9]}) &&
                 ((acc < DEC_LIMIT) || ((acc == DEC_LIMIT) && (d <= 4'd5)));
        if (r.good) begin
          r.acc = ({acc[ValueWidth-4:0], 3'b000} + {acc[ValueWidth-2:0], 1'b0}) +
                  {{(ValueWidth-4){1'b0}}, d};
        end
      end
    endcase
    return r;
  endfunction

endpackage

/* sv/ttoi_char_if.sv */
interface ttoi_char_if import ttoi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

/* sv/ttoi_result_if.sv */
interface ttoi_result_if import ttoi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [ValueWidth-1:0] value;

  modport source (output valid, output ok, output value, input ready);
  modport sink (input valid, input ok, input value, output ready);
endinterface

/* sv/ttoi_cfg_if.sv */
interface ttoi_cfg_if import ttoi_pkg::*; ();
  logic                valid;
  logic                ready;
  reg_index_t          index;
  logic [CfgWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/text_to_int64_parser.sv */
// Channel  | Direction | Payload                 | Item
// ---------+-----------+-------------------------+-----------------------------------
// chars    | in        | char_code[15:0]         | one character, zero ends a number
// result   | out       | ok, value[63:0]         | one per terminator
// cfg      | in        | index, data[1:0]        | register write, always ready
//
// One character is accepted per cycle unless the input stalls. An accepted character
// is parsed from the parse register, and a terminator's result is registered.
// The input only stalls when a terminator waits in the parse register while
// the result register still holds an untaken item.
// Reset clears the parse state, both config registers and all valid flags.
module text_to_int64_parser import ttoi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  ttoi_char_if.sink           chars,
  ttoi_result_if.source       result,
  ttoi_cfg_if.sink            cfg
);

  base_t                 base_mode;
  logic                  signed_mode;

  logic                  s1_valid;
  logic [CharWidth-1:0]  s1_char;

  logic [ValueWidth-1:0] accumulator, accumulator_next;
  base_t                 active_base, active_base_next;
  phase_t                parse_phase, parse_phase_next;
  logic                  is_negative, is_negative_next;
  logic                  error_seen, error_seen_next;

  logic                  is_term;
  logic                  go;
  logic                  term_good;
  logic [ValueWidth-1:0] term_value;
  logic                  do_add;
  base_t                 eff_base;
  digit_res_t            dig;

  assign cfg.ready   = 1'b1;
  assign is_term     = (s1_char == CH_NUL);
  assign go          = s1_valid && (!is_term || !result.valid || result.ready);
  assign chars.ready = !s1_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode   <= BASE_AUTO;
      signed_mode <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_BASE_MODE:   base_mode   <= base_t'(cfg.data);
        REG_SIGNED_MODE: signed_mode <= cfg.data[0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) s1_char <= chars.char_code;
  end

  always_comb begin
    accumulator_next = accumulator;
    active_base_next = active_base;
    parse_phase_next = parse_phase;
    is_negative_next = is_negative;
    error_seen_next  = error_seen;
    do_add           = 1'b0;
    eff_base         = active_base;
    dig              = '0;
    term_good        = 1'b0;
    term_value       = '0;

    if (is_term) begin
      term_good = !error_seen && (parse_phase != PH_START) && (parse_phase != PH_MINUS);
      if (is_negative) begin
        if (accumulator > NEG_LIMIT) term_good = 1'b0;
        else term_value = -accumulator;
      end else if (signed_mode && (accumulator > POS_LIMIT)) begin
        term_good = 1'b0;
      end else begin
        term_value = accumulator;
      end
      if (!term_good) term_value = '0;
      accumulator_next = '0;
      active_base_next = base_mode;
      parse_phase_next = PH_START;
      is_negative_next = 1'b0;
      error_seen_next  = 1'b0;
    end else if (!error_seen) begin
      case (parse_phase)
        PH_START, PH_MINUS: begin
          if (parse_phase == PH_START) eff_base = base_mode;
          active_base_next = eff_base;
          if ((parse_phase == PH_START) && signed_mode && (s1_char == CH_MINUS)) begin
            is_negative_next = 1'b1;
            parse_phase_next = PH_MINUS;
          end else if ((eff_base == BASE_AUTO) && (s1_char == CH_0)) begin
            parse_phase_next = PH_ZERO;
          end else begin
            if (eff_base == BASE_AUTO) eff_base = BASE_DEC;
            active_base_next = eff_base;
            parse_phase_next = PH_DIGITS;
            do_add           = 1'b1;
          end
        end
        PH_ZERO: begin
          parse_phase_next = PH_DIGITS;
          if ((s1_char == CH_LX) || (s1_char == CH_UX)) begin
            active_base_next = BASE_HEX;
          end else begin
            eff_base         = BASE_OCT;
            active_base_next = BASE_OCT;
            do_add           = 1'b1;
          end
        end
        default: begin
          parse_phase_next = PH_DIGITS;
          do_add           = 1'b1;
        end
      endcase
      if (do_add) begin
        dig = add_digit(eff_base, accumulator, s1_char);
        if (dig.good) accumulator_next = dig.acc;
        else error_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      active_base <= BASE_AUTO;
      parse_phase <= PH_START;
      is_negative <= 1'b0;
      error_seen  <= 1'b0;
    end else if (go) begin
      accumulator <= accumulator_next;
      active_base <= active_base_next;
      parse_phase <= parse_phase_next;
      is_negative <= is_negative_next;
      error_seen  <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (go && is_term) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && is_term) begin
      result.ok    <= term_good;
      result.value <= term_value;
    end
  end

endmodule

/* sv/ttoi_check.sv */
module ttoi_check import ttoi_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_ok,
  input logic [ValueWidth-1:0] out_value
);

  // A failed parse always reports a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ok) |-> (out_value == '0))
    else $error("failed result carries a nonzero value");

  // The input side only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // A result that is not taken holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_ok) && $stable(out_value)))
    else $error("stalled result changed");

endmodule

bind text_to_int64_parser ttoi_check u_ttoi_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (chars.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_ok    (result.ok),
  .out_value (result.value)
);

/* tb/sv/tb_text_to_int64_parser.sv */
module tb_text_to_int64_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import ttoi_pkg::*;

  typedef struct packed {
    logic                  ok;
    logic [ValueWidth-1:0] value;
  } parse_result_t;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASE_CHARS = 190;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ttoi_char_if   chars_ch ();
  ttoi_result_if result_ch ();
  ttoi_cfg_if    cfg_ch ();

  text_to_int64_parser u_top (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Characters waiting to be offered, and the numbers expected back.
  logic [CharWidth-1:0] char_stream[$];
  parse_result_t        expected_results[$];
  int unsigned          chars_queued;
  int unsigned          mismatch_count;
  int unsigned          stall_cycles;
  int unsigned          hold_left;

  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done;

  // Register copies and parse state of the predictor.
  base_t                 cur_base;
  bit                    cur_signed;
  logic [ValueWidth-1:0] parse_acc;
  base_t                 parse_base;
  phase_t                parse_phase;
  bit                    parse_neg;
  bit                    parse_err;

  parse_result_t         want;

  task automatic clear_parse();
    parse_acc   = '0;
    parse_base  = cur_base;
    parse_phase = PH_START;
    parse_neg   = 1'b0;
    parse_err   = 1'b0;
  endtask

  // Folds one character into the accumulator; returns 0 on a bad digit or overflow.
  function automatic bit fold_digit(logic [CharWidth-1:0] c);
    logic [ValueWidth-1:0] d;
    d = '0;
    case (parse_base)
      BASE_HEX: begin
        if (c >= CH_0 && c <= CH_9) d = ValueWidth'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF) d = ValueWidth'(c - CH_LA + 16'd10);
        else if (c >= CH_UA && c <= CH_UF) d = ValueWidth'(c - CH_UA + 16'd10);
        else return 1'b0;
        if (parse_acc > HEX_LIMIT) return 1'b0;
        parse_acc = (parse_acc << 4) + d;
        return 1'b1;
      end
      BASE_OCT: begin
        if (c < CH_0 || c > CH_7) return 1'b0;
        if (parse_acc > OCT_LIMIT) return 1'b0;
        d = ValueWidth'(c - CH_0);
        parse_acc = (parse_acc << 3) + d;
        return 1'b1;
      end
      default: begin
        if (c < CH_0 || c > CH_9) return 1'b0;
        d = ValueWidth'(c - CH_0);
        if (parse_acc > DEC_LIMIT) return 1'b0;
        if (parse_acc == DEC_LIMIT && d > 5) return 1'b0;
        parse_acc = parse_acc * 64'd10 + d;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic predict_char(logic [CharWidth-1:0] c);
    bit                    good;
    logic [ValueWidth-1:0] v;
    if (c == CH_NUL) begin
      v    = '0;
      good = !parse_err && parse_phase != PH_START && parse_phase != PH_MINUS;
      if (good) begin
        if (parse_neg) begin
          if (parse_acc > NEG_LIMIT) good = 1'b0;
          else v = -parse_acc;
        end else if (cur_signed && parse_acc > POS_LIMIT) begin
          good = 1'b0;
        end else begin
          v = parse_acc;
        end
      end
      expected_results.push_back('{ok: good, value: good ? v : '0});
      clear_parse();
      return;
    end
    if (parse_err) return;
    good = 1'b1;
    case (parse_phase)
      PH_START, PH_MINUS: begin
        if (parse_phase == PH_START) begin
          parse_base = cur_base;
          if (cur_signed && c == CH_MINUS) begin
            parse_neg   = 1'b1;
            parse_phase = PH_MINUS;
            return;
          end
        end
        if (parse_base == BASE_AUTO) begin
          if (c == CH_0) begin
            parse_phase = PH_ZERO;
            return;
          end
          parse_base = BASE_DEC;
        end
        parse_phase = PH_DIGITS;
        good = fold_digit(c);
      end
      PH_ZERO: begin
        parse_phase = PH_DIGITS;
        if (c == CH_LX || c == CH_UX) begin
          parse_base = BASE_HEX;
          return;
        end
        parse_base = BASE_OCT;
        good = fold_digit(c);
      end
      default: begin
        parse_phase = PH_DIGITS;
        good = fold_digit(c);
      end
    endcase
    if (!good) parse_err = 1'b1;
  endtask

  // Character driver: holds an offered item until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      chars_ch.valid <= 1'b0;
    end else if (!chars_ch.valid || chars_ch.ready) begin
      if (char_stream.size() != 0 && !(tx_idle_en && $urandom_range(99) < 32)) begin
        chars_ch.valid     <= 1'b1;
        chars_ch.char_code <= char_stream.pop_front();
      end else begin
        chars_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off to back the block up.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
      long_hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      result_ch.ready <= 1'b0;
      hold_left       <= LONG_HOLD;
      long_hold_done  <= 1'b1;
    end else begin
      result_ch.ready <= !(rx_idle_en && $urandom_range(99) < 32);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (chars_ch.valid && chars_ch.ready) predict_char(chars_ch.char_code);
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: ok %0b value %h",
                 result_ch.ok, result_ch.value);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (result_ch.ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, result_ch.ok);
            mismatch_count++;
          end
          if (result_ch.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, result_ch.value);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (chars_ch.valid && chars_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_char(logic [CharWidth-1:0] c);
    char_stream.push_back(c);
    chars_queued++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) push_char({8'h00, s[i]});
    push_char(CH_NUL);
  endtask

  function automatic logic [CharWidth-1:0] digit_char(int unsigned dv);
    if (dv < 10) return CH_0 + 16'(dv);
    if ($urandom_range(1)) return CH_UA + 16'(dv - 10);
    return CH_LA + 16'(dv - 10);
  endfunction

  function automatic logic [CharWidth-1:0] glitch_char();
    case ($urandom_range(7))
      0: return CH_MINUS;
      1: return CH_LX;
      2: return CH_UX;
      3: return CH_7 + 16'd1;
      4: return CH_LF + 16'd1;
      5: return 16'h0020;
      6: return CH_0;
      default: return 16'($urandom);
    endcase
  endfunction

  // One number in the active base, sometimes near a limit, overlong or spoiled.
  task automatic add_number();
    logic [CharWidth-1:0]  text[$];
    logic [CharWidth-1:0]  digs[$];
    logic [ValueWidth-1:0] mag;
    base_t                 b;
    bit                    neg;
    int unsigned           radix;
    int unsigned           extra;
    int unsigned           zeros;
    int unsigned           pos;
    if (cur_base == BASE_AUTO) begin
      case ($urandom_range(2))
        0: b = BASE_OCT;
        1: b = BASE_DEC;
        default: b = BASE_HEX;
      endcase
    end else begin
      b = cur_base;
    end
    radix = (b == BASE_HEX) ? 16 : (b == BASE_OCT) ? 8 : 10;
    neg   = cur_signed && ($urandom_range(2) == 0);
    extra = 0;
    case ($urandom_range(9))
      0, 1, 2: mag = 64'($urandom_range(5000));
      3, 4:    mag = {$urandom, $urandom};
      5:       mag = {$urandom, $urandom} >> $urandom_range(63);
      6, 7, 9: begin
        case ($urandom_range(5))
          0: mag = POS_LIMIT;
          1: mag = NEG_LIMIT;
          2: mag = '1;
          3: mag = HEX_LIMIT;
          4: mag = OCT_LIMIT;
          default: mag = DEC_LIMIT;
        endcase
        mag = mag + 64'($urandom_range(2)) - 64'd1;
      end
      default: mag = '0;
    endcase
    if ($urandom_range(9) == 0) extra = $urandom_range(1, 2);
    zeros = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
    if (cur_base == BASE_AUTO && b == BASE_DEC) zeros = 0;
    do begin
      digs.push_front(digit_char(32'(mag % radix)));
      mag = mag / radix;
    end while (mag != 0);
    repeat (extra) digs.push_back(digit_char($urandom_range(radix - 1)));
    if (neg) text.push_back(CH_MINUS);
    if (cur_base == BASE_AUTO && b != BASE_DEC) begin
      text.push_back(CH_0);
      if (b == BASE_HEX) text.push_back($urandom_range(1) ? CH_UX : CH_LX);
    end
    repeat (zeros) text.push_back(CH_0);
    foreach (digs[i]) text.push_back(digs[i]);
    if ($urandom_range(7) == 0) begin
      pos = $urandom_range(text.size());
      if (pos == text.size()) text.push_back(glitch_char());
      else text.insert(pos, glitch_char());
    end
    foreach (text[i]) push_char(text[i]);
    push_char(CH_NUL);
  endtask

  task automatic add_string();
    if ($urandom_range(9) == 0) begin
      // Noise: raw wide characters; a zero among them just ends the string early.
      repeat ($urandom_range(6)) push_char(16'($urandom));
      push_char(CH_NUL);
    end else begin
      add_number();
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (char_stream.size() != 0 || chars_ch.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Both registers go in back to back; valid stays high between the two items.
  task automatic write_config(base_t b, bit s);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_BASE_MODE;
    cfg_ch.data  <= b;
    do @(posedge clk); while (!cfg_ch.ready);
    cur_base = b;
    cfg_ch.index <= REG_SIGNED_MODE;
    cfg_ch.data  <= {1'b0, s};
    do @(posedge clk); while (!cfg_ch.ready);
    cur_signed = s;
    cfg_ch.valid <= 1'b0;
  endtask

  base_t plan_base[10] = '{BASE_OCT, BASE_DEC, BASE_HEX, BASE_HEX, BASE_AUTO,
                           BASE_OCT, BASE_DEC, BASE_AUTO, BASE_AUTO, BASE_HEX};
  bit    plan_signed[10] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  initial begin
    int unsigned phase_start;
    base_t       b;
    bit          s;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_BASE_MODE;
    cfg_ch.data        = '0;
    cur_base           = BASE_AUTO;
    cur_signed         = 1'b0;
    clear_parse();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: prefix detection, unsigned.
    add_text("");
    add_text("0");
    add_text("0x");
    add_text("0Xf");
    add_text("-7");
    push_char(16'hffff);
    push_char(CH_NUL);
    push_char(CH_0 | 16'h0100);
    push_char(CH_NUL);

    for (int i = 0; i < 10; i++) begin
      wait_drained();
      b = plan_base[i];
      s = plan_signed[i];
      if (i >= 8) begin
        b = base_t'($urandom_range(3));
        s = $urandom_range(1);
      end
      write_config(b, s);
      tx_idle_en <= (i != 2);
      rx_idle_en <= (i != 2);
      if (i == 4) long_hold_req <= 1'b1;
      phase_start = chars_queued;
      if (s) add_text("-");
      while (chars_queued - phase_start < PHASE_CHARS) add_string();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ttoi_pkg.sv
sv/ttoi_char_if.sv
sv/ttoi_result_if.sv
sv/ttoi_cfg_if.sv
sv/text_to_int64_parser.sv
sv/ttoi_check.sv
tb/sv/tb_text_to_int64_parser.sv
